@@ rtl/fmg_pkg.sv @@
// Shared types and constants of the gradient focus measure block.
// No dependencies; every other RTL file imports this package.
package fmg_pkg;

	// Field widths fixed by the stream format
	localparam int PIX_W   = 8;
	localparam int CFG_W   = 13;
	localparam int TOTAL_W = 50;
	localparam int MEAN_W  = 26;
	localparam int DIV_W   = 26;
	localparam int SUM_W   = 10;
	localparam int GRAD_W  = 26;

	// Q0.15 weights of edge and diagonal neighbours
	localparam int EDGE_SHIFT = 15;
	localparam logic [14:0] DIAG_WEIGHT = 15'd23170;

	// Largest mean that can ever be produced
	localparam logic [MEAN_W-1:0] MEAN_MAX = 26'd57056760;

	// Frame-result queue between the pixel front end and the divider
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W      = 2;
	localparam int QPTR_W      = 1;

	// Configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Divider iteration count (one quotient bit per cycle)
	localparam int ITER_W = 6;
	localparam logic [ITER_W-1:0] ITER_LAST = 6'(TOTAL_W - 1);

	// One finished frame: accumulated total and the interior pixel count
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [DIV_W-1:0]   divisor;
	} job_t;

	// Push side of the queue
	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	// Divider sequencer states
	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

endpackage

@@ rtl/fmg_stream_if.sv @@
// Valid/ready stream interfaces for pixels in and frame means out.
// Depends on fmg_pkg for the field widths.
interface fmg_pixel_if;
	import fmg_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] grey_pixel;
	modport source (output valid, output grey_pixel, input ready);
	modport sink (input valid, input grey_pixel, output ready);
endinterface

interface fmg_mean_if;
	import fmg_pkg::*;
	logic              valid;
	logic              ready;
	logic [MEAN_W-1:0] focus_mean;
	modport source (output valid, output focus_mean, input ready);
	modport sink (input valid, input focus_mean, output ready);
endinterface

@@ rtl/fmg_front.sv @@
// Pixel front end: counters, line store, 3x3 window, gradient pipeline, accumulator.
// Depends on fmg_pkg; pushes one job_t per frame into fmg_queue.
module fmg_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fmg_pkg::PIX_W-1:0]   grey_pixel,
	input  logic [fmg_pkg::CFG_W-1:0]   frame_width,
	input  logic [fmg_pkg::CFG_W-1:0]   frame_height,
	input  logic [fmg_pkg::QCNT_W-1:0]  queue_used,
	output fmg_pkg::push_t              push
);
	import fmg_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [WW-1:0] w_c;
	logic [HW-1:0] h_c;
	logic [DIV_W-1:0] divisor_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept;
	logic          line_end;
	logic          frame_end;
	logic          interior;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] line_rd_s1;

	logic             valid_s1, inner_s1, end_s1;
	logic [PIX_W-1:0] px_s1;
	logic [CW-1:0]    col_s1;
	logic [PIX_W-1:0] win_q [9];

	logic valid_s2, inner_s2, end_s2;

	logic             valid_s3, inner_s3, end_s3;
	logic [SUM_W-1:0] edge_s3, diag_s3;
	logic [SUM_W-1:0] edge_sum, diag_sum;

	logic              valid_s4, inner_s4, end_s4;
	logic [GRAD_W-1:0] grad_s4;

	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_next;
	logic [QCNT_W:0]    ends_in_flight;

	// Clamp the frame size into the supported range
	always_comb begin
		if (frame_width < CFG_W'(3))
			w_c = WW'(3);
		else if (32'(frame_width) > 32'(MAX_WIDTH))
			w_c = WW'(MAX_WIDTH);
		else
			w_c = WW'(frame_width);
		if (frame_height < CFG_W'(3))
			h_c = HW'(3);
		else if (32'(frame_height) > 32'(MAX_HEIGHT))
			h_c = HW'(MAX_HEIGHT);
		else
			h_c = HW'(frame_height);
	end

	// Interior pixel count of a frame; the user must keep the size static while a frame runs (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= '0;
		end else begin
			divisor_q <= (DIV_W'(h_c) - DIV_W'(2)) * (DIV_W'(w_c) - DIV_W'(2));
		end
	end

	// Hold input while the queue could not take every frame still in the pipe
	always_comb begin
		ends_in_flight = (QCNT_W+1)'(valid_s1 & end_s1) + (QCNT_W+1)'(valid_s2 & end_s2)
			+ (QCNT_W+1)'(valid_s3 & end_s3) + (QCNT_W+1)'(valid_s4 & end_s4);
		in_ready = ((QCNT_W+1)'(queue_used) + ends_in_flight) < (QCNT_W+1)'(QUEUE_DEPTH);
	end

	assign accept    = in_valid && in_ready;
	assign line_end  = (32'(col_q) + 32'd1) >= 32'(w_c);
	assign frame_end = line_end && ((32'(row_q) + 32'd1) >= 32'(h_c));
	assign interior  = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);

	// Advance the raster position on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				if (frame_end)
					row_q <= '0;
				else
					row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Line store: upper byte two lines back, lower byte one line back
	always_ff @(posedge clk) begin
		if (valid_s1)
			line_mem[col_s1] <= {line_rd_s1[PIX_W-1:0], px_s1};
		if (accept)
			line_rd_s1 <= line_mem[col_q];
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			inner_s1 <= 1'b0;
			end_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			inner_s1 <= interior;
			end_s1   <= frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= grey_pixel;
			col_s1 <= col_q;
		end
	end

	// Shift the 3x3 window one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= line_rd_s1[2*PIX_W-1:PIX_W];
			win_q[5] <= line_rd_s1[PIX_W-1:0];
			win_q[8] <= px_s1;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			inner_s2 <= 1'b0;
			end_s2   <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			inner_s2 <= inner_s1;
			end_s2   <= end_s1;
		end
	end

	// Sum absolute differences to edge and diagonal neighbours
	function automatic logic [SUM_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a > b) ? SUM_W'(a - b) : SUM_W'(b - a);
	endfunction

	always_comb begin
		edge_sum = abs_diff(win_q[4], win_q[1]) + abs_diff(win_q[4], win_q[3])
			+ abs_diff(win_q[4], win_q[5]) + abs_diff(win_q[4], win_q[7]);
		diag_sum = abs_diff(win_q[4], win_q[0]) + abs_diff(win_q[4], win_q[2])
			+ abs_diff(win_q[4], win_q[6]) + abs_diff(win_q[4], win_q[8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			inner_s3 <= 1'b0;
			end_s3   <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			inner_s3 <= inner_s2;
			end_s3   <= end_s2;
		end
	end

	always_ff @(posedge clk) begin
		edge_s3 <= edge_sum;
		diag_s3 <= diag_sum;
	end

	// Weight the two sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			inner_s4 <= 1'b0;
			end_s4   <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			inner_s4 <= inner_s3;
			end_s4   <= end_s3;
		end
	end

	always_ff @(posedge clk) begin
		grad_s4 <= (GRAD_W'(edge_s3) << EDGE_SHIFT) + GRAD_W'(diag_s3) * GRAD_W'(DIAG_WEIGHT);
	end

	// Accumulate interior gradients; hand the total over at frame end
	assign total_next = inner_s4 ? total_q + TOTAL_W'(grad_s4) : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (valid_s4) begin
			if (end_s4)
				total_q <= '0;
			else
				total_q <= total_next;
		end
	end

	always_comb begin
		push.valid       = valid_s4 && end_s4;
		push.job.total   = total_next;
		push.job.divisor = divisor_q;
	end

endmodule

@@ rtl/fmg_queue.sv @@
// Short queue of finished frames between the front end and the divider.
// Depends on fmg_pkg for job_t and the queue depth.
module fmg_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fmg_pkg::push_t              push,
	output logic [fmg_pkg::QCNT_W-1:0]  used,
	output logic                        pop_valid,
	input  logic                        pop_ready,
	output fmg_pkg::job_t               pop_job
);
	import fmg_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] used_q;
	logic              do_pop;

	assign do_pop    = pop_valid && pop_ready;
	assign pop_valid = used_q != '0;
	assign pop_job   = slot_q[rd_q];
	assign used      = used_q;

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push.valid)
			slot_q[wr_q] <= push.job;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			used_q <= '0;
		end else begin
			if (push.valid)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			case ({push.valid, do_pop})
				2'b10:   used_q <= used_q + QCNT_W'(1);
				2'b01:   used_q <= used_q - QCNT_W'(1);
				default: used_q <= used_q;
			endcase
		end
	end

endmodule

@@ rtl/fmg_divider.sv @@
// Back end: restoring divider, one quotient bit per cycle, and the output register.
// Depends on fmg_pkg and fmg_mean_if; takes jobs from fmg_queue.
module fmg_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  fmg_pkg::job_t  job,
	fmg_mean_if.source     results
);
	import fmg_pkg::*;

	div_state_t         state_q;
	logic [ITER_W-1:0]  iter_q;
	logic [TOTAL_W-1:0] num_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIV_W:0]     trial;
	logic [DIV_W:0]     diff;
	logic               fits;
	logic               slot_free;
	logic               out_valid_q;
	logic [MEAN_W-1:0]  out_data_q;

	assign job_ready = state_q == DIV_IDLE;
	assign slot_free = !out_valid_q || results.ready;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	assign trial = {rem_q, num_q[TOTAL_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				DIV_IDLE: begin
					if (job_valid) begin
						state_q <= DIV_RUN;
						iter_q  <= '0;
					end
				end
				DIV_RUN: begin
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_LAST)
						state_q <= DIV_DONE;
				end
				DIV_DONE: begin
					if (slot_free)
						state_q <= DIV_IDLE;
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

	// Datapath of the divider
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && job_valid) begin
			num_q <= job.total;
			div_q <= job.divisor;
			rem_q <= '0;
		end else if (state_q == DIV_RUN) begin
			num_q <= {num_q[TOTAL_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	// Output register: hold the mean until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == DIV_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_DONE && slot_free)
			out_data_q <= num_q[MEAN_W-1:0];
	end

	assign results.valid      = out_valid_q;
	assign results.focus_mean = out_data_q;

endmodule

@@ rtl/focus_measure_gradient_mean_core.sv @@
// Gradient focus measure: top level with the configuration registers.
// Depends on fmg_pkg, fmg_stream_if, fmg_front, fmg_queue and fmg_divider.
//
// Takes one grey pixel per clock in raster order and, once per frame, gives the
// mean weighted 8-neighbour gradient of the interior pixels in Q.15 units. A pixel
// is taken every cycle that the input is ready; it passes a four-stage pipeline
// (line-store read, window, difference sums, weighting) into the accumulator. On
// the last pixel of a frame the total joins a two-entry frame queue; a restoring
// divider produces one quotient bit per cycle. The pixel input holds off only
// while the queue and the frames still in the pipeline would fill it, so frames
// shorter than the divide time see stalls. The line store is a MAX_WIDTH x 16-bit
// memory with no clearing pass. The user must write frame_width and frame_height
// only between frames; the block does not enforce it.
module focus_measure_gradient_mean_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [fmg_pkg::CFG_W-1:0] cfg_data,
	fmg_pixel_if.sink                 pixels,
	fmg_mean_if.source                results
);
	import fmg_pkg::*;

	logic [CFG_W-1:0]  frame_width_q;
	logic [CFG_W-1:0]  frame_height_q;
	logic [QCNT_W-1:0] queue_used;
	push_t             push;
	logic              job_valid;
	logic              job_ready;
	job_t              job;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_W'(640);
			frame_height_q <= CFG_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fmg_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pixels.valid),
		.in_ready     (pixels.ready),
		.grey_pixel   (pixels.grey_pixel),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.queue_used   (queue_used),
		.push         (push)
	);

	fmg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.used      (queue_used),
		.pop_valid (job_valid),
		.pop_ready (job_ready),
		.pop_job   (job)
	);

	fmg_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.results   (results)
	);

endmodule

@@ rtl/fmg_checker.sv @@
// Port-level checks of the gradient focus measure, bound to the top level.
// Depends on fmg_pkg and focus_measure_gradient_mean_core.
module fmg_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pix_valid,
	input logic                       pix_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [fmg_pkg::MEAN_W-1:0] focus_mean
);
	import fmg_pkg::*;

	logic [3:0] seen_q;

	// Count transferred pixels since reset, saturating at nine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= '0;
		else if (pix_valid && pix_ready && seen_q != 4'd9)
			seen_q <= seen_q + 4'd1;
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before transfer");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(focus_mean))
		else $error("result changed while stalled");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> focus_mean <= MEAN_MAX)
		else $error("mean above the largest possible gradient");

	a_res_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> seen_q == 4'd9)
		else $error("result before a minimal frame was taken");

endmodule

bind focus_measure_gradient_mean_core fmg_checker u_fmg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pixels.valid),
	.pix_ready  (pixels.ready),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.focus_mean (results.focus_mean)
);
